### design/cell_list_neighbor_ranges_defines.svh
// assertion macros shared by the checker
`ifndef CELL_LIST_NEIGHBOR_RANGES_DEFINES_SVH
`define CELL_LIST_NEIGHBOR_RANGES_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define CLNR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clnr port check failed");

// next-cycle implication
`define CLNR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clnr port check failed");

`endif

### design/clnr_pkg.sv
`timescale 1ns / 1ps

package clnr_pkg;

   // table geometry
   localparam int NUM_CELLS     = 4096;
   localparam int CELL_W        = $clog2(NUM_CELLS);
   localparam int FIRST_W       = 16;
   localparam int TOTAL_W       = 7;
   localparam int RANK_W        = 12;
   localparam int CELL_CAPACITY = 64;

   // offset registers
   localparam int OFFSET_W    = 13;
   localparam int STEP_W      = OFFSET_W + 2;
   localparam int CSR_COUNT   = 6;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_PLUS  = 3'd0,
      CSR_X_MINUS = 3'd1,
      CSR_Y_PLUS  = 3'd2,
      CSR_Y_MINUS = 3'd3,
      CSR_Z_PLUS  = 3'd4,
      CSR_Z_MINUS = 3'd5
   } csr_index_type;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [CELL_W-1:0]  cell_index;
      logic [FIRST_W-1:0] atom_first_in;
      logic [TOTAL_W-1:0] atom_total_in;
      logic [RANK_W-1:0]  cell_rank_in;
   } clnr_req_type;

   typedef struct packed {
      logic [FIRST_W-1:0] range_first;
      logic [TOTAL_W-1:0] range_total;
      logic [CELL_W-1:0]  source_cell;
      logic               last_range;
   } clnr_rsp_type;

   // one table entry as held in the cell memory
   typedef struct packed {
      logic [FIRST_W-1:0] first;
      logic [TOTAL_W-1:0] total;
      logic [RANK_W-1:0]  rank;
   } clnr_entry_type;

endpackage

### design/cell_list_neighbor_ranges.sv
`timescale 1ns / 1ps

// cell list neighbour range generator. a write transaction (req_type 0) loads one
// cell entry and returns nothing; busy stays low, so writes may
// follow each other in every cycle. a query transaction (req_type 1) raises busy
// and reads the cell table once per cycle: its own cell, then the 26 neighbours
// in i,j,k order, so the single read port of the table sets the pace. the last
// read returns from the registered table output; when the last neighbour is itself
// emitted, its held range is drained through the flush register before busy falls.
// results appear on rsp_data for one cycle each under rsp_valid
// and cannot be held off: the receiver must take every one as it comes. the own
// range comes first, then each neighbour whose rank is at least the queried
// cell's rank, and the final range of a query carries last_range. offset
// registers may only be written while busy is low and no results are still to come.
module cell_list_neighbor_ranges (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  clnr_pkg::clnr_req_type                 req_data,
   output logic                                   rsp_valid,
   output clnr_pkg::clnr_rsp_type                 rsp_data,
   input  logic                                   csr_we,
   input  logic [clnr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [clnr_pkg::OFFSET_W-1:0]          csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // per-axis neighbour direction
   typedef enum logic [1:0] {
      DIR_MINUS,
      DIR_ZERO,
      DIR_PLUS
   } dir_type;

   state_type state_ff;
   dir_type   di_ff, dj_ff, dk_ff;
   dir_type   di_in, dj_in, dk_in;

   logic signed [clnr_pkg::OFFSET_W-1:0] offset_ff [clnr_pkg::CSR_COUNT];

   logic [clnr_pkg::CELL_W-1:0] cell_ff;
   logic [clnr_pkg::RANK_W-1:0] own_rank_ff;

   // read tag travelling alongside the memory latency
   logic                        rd_valid_ff;
   logic                        rd_own_ff;
   logic                        rd_last_ff;
   logic [clnr_pkg::CELL_W-1:0] rd_cell_ff;

   // held-back range, so the last flag can be set once the scan is done
   clnr_pkg::clnr_rsp_type pend_ff;
   logic                   flush_ff;

   logic                   rsp_valid_ff;
   clnr_pkg::clnr_rsp_type rsp_ff;

   logic                        accept;
   logic                        accept_query;
   logic                        accept_write;
   logic                        scan_done;
   logic                        rd_en;
   logic [clnr_pkg::CELL_W-1:0] rd_addr;
   logic [clnr_pkg::CELL_W-1:0] nb_addr;
   logic signed [clnr_pkg::STEP_W-1:0] step_x, step_y, step_z, nb_sum;
   clnr_pkg::clnr_entry_type    wr_entry;
   clnr_pkg::clnr_entry_type    rd_entry;
   logic                        nb_hit;

   assign busy         = (state_ff != ST_IDLE) | rd_valid_ff | flush_ff;
   assign accept       = start & ~busy;
   assign accept_query = accept & (req_data.req_type == clnr_pkg::REQ_QUERY);
   assign accept_write = accept & (req_data.req_type == clnr_pkg::REQ_WRITE);

   // write entry, count saturated to cell capacity
   always_comb begin
      wr_entry.first = req_data.atom_first_in;
      wr_entry.rank  = req_data.cell_rank_in;
      if (req_data.atom_total_in > clnr_pkg::TOTAL_W'(clnr_pkg::CELL_CAPACITY)) begin
         wr_entry.total = clnr_pkg::TOTAL_W'(clnr_pkg::CELL_CAPACITY);
      end else begin
         wr_entry.total = req_data.atom_total_in;
      end
   end

   // per-axis steps of the current neighbour
   always_comb begin
      case (di_ff)
         DIR_PLUS:  step_x = clnr_pkg::STEP_W'(offset_ff[clnr_pkg::CSR_X_PLUS]);
         DIR_MINUS: step_x = clnr_pkg::STEP_W'(offset_ff[clnr_pkg::CSR_X_MINUS]);
         default:   step_x = '0;
      endcase
      case (dj_ff)
         DIR_PLUS:  step_y = clnr_pkg::STEP_W'(offset_ff[clnr_pkg::CSR_Y_PLUS]);
         DIR_MINUS: step_y = clnr_pkg::STEP_W'(offset_ff[clnr_pkg::CSR_Y_MINUS]);
         default:   step_y = '0;
      endcase
      case (dk_ff)
         DIR_PLUS:  step_z = clnr_pkg::STEP_W'(offset_ff[clnr_pkg::CSR_Z_PLUS]);
         DIR_MINUS: step_z = clnr_pkg::STEP_W'(offset_ff[clnr_pkg::CSR_Z_MINUS]);
         default:   step_z = '0;
      endcase
   end

   // wrap modulo the table size: keep the low index bits of the two's complement sum
   assign nb_sum  = $signed({{(clnr_pkg::STEP_W-clnr_pkg::CELL_W){1'b0}}, cell_ff})
                    + step_x + step_y + step_z;
   assign nb_addr = nb_sum[clnr_pkg::CELL_W-1:0];

   // next neighbour in i,j,k order, centre skipped
   always_comb begin
      di_in = di_ff;
      dj_in = dj_ff;
      dk_in = dk_ff;
      if (dk_ff != DIR_PLUS) begin
         dk_in = dir_type'(dk_ff + 2'd1);
      end else begin
         dk_in = DIR_MINUS;
         if (dj_ff != DIR_PLUS) begin
            dj_in = dir_type'(dj_ff + 2'd1);
         end else begin
            dj_in = DIR_MINUS;
            di_in = dir_type'(di_ff + 2'd1);
         end
      end
      if (di_in == DIR_ZERO && dj_in == DIR_ZERO && dk_in == DIR_ZERO) begin
         dk_in = DIR_PLUS;
      end
   end

   assign scan_done = (di_ff == DIR_PLUS) && (dj_ff == DIR_PLUS) && (dk_ff == DIR_PLUS);
   assign rd_en     = accept_query | (state_ff == ST_SCAN);
   assign rd_addr   = accept_query ? req_data.cell_index : nb_addr;

   // no write can land during a scan since busy holds the request side off
   clnr_cell_ram u_cell_ram (
      .clock   (clock),
      .wr_en   (accept_write),
      .wr_addr (req_data.cell_index),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign nb_hit = rd_entry.rank >= own_rank_ff;

   // offset registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < clnr_pkg::CSR_COUNT; r++) begin
            offset_ff[r] <= '0;
         end
      end else if (csr_we && (csr_index < clnr_pkg::CSR_INDEX_W'(clnr_pkg::CSR_COUNT))) begin
         offset_ff[csr_index] <= csr_wdata;
      end
   end

   // scan sequencer, result staging and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         di_ff        <= DIR_MINUS;
         dj_ff        <= DIR_MINUS;
         dk_ff        <= DIR_MINUS;
         rd_valid_ff  <= 1'b0;
         rd_own_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_en;
         rd_own_ff    <= accept_query;
         rd_last_ff   <= (state_ff == ST_SCAN) && scan_done;

         case (state_ff)
            ST_IDLE: begin
               if (accept_query) begin
                  state_ff <= ST_SCAN;
                  di_ff    <= DIR_MINUS;
                  dj_ff    <= DIR_MINUS;
                  dk_ff    <= DIR_MINUS;
               end
            end
            ST_SCAN: begin
               di_ff <= di_in;
               dj_ff <= dj_in;
               dk_ff <= dk_in;
               if (scan_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // read data back from the table: the own range is held until the next
         // one is known, a hit on the last neighbour leaves one range to flush
         if (rd_valid_ff) begin
            rsp_valid_ff <= ~rd_own_ff & (nb_hit | rd_last_ff);
            flush_ff     <= ~rd_own_ff & nb_hit & rd_last_ff;
         end else begin
            rsp_valid_ff <= flush_ff;
            flush_ff     <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept_query) begin
         cell_ff <= req_data.cell_index;
      end
      if (rd_en) begin
         rd_cell_ff <= rd_addr;
      end
      if (rd_valid_ff) begin
         if (rd_own_ff) begin
            own_rank_ff <= rd_entry.rank;
            pend_ff     <= '{range_first: rd_entry.first, range_total: rd_entry.total,
                             source_cell: rd_cell_ff, last_range: 1'b0};
         end else if (nb_hit) begin
            rsp_ff  <= pend_ff;
            pend_ff <= '{range_first: rd_entry.first, range_total: rd_entry.total,
                         source_cell: rd_cell_ff, last_range: 1'b0};
         end else if (rd_last_ff) begin
            rsp_ff <= '{range_first: pend_ff.range_first, range_total: pend_ff.range_total,
                        source_cell: pend_ff.source_cell, last_range: 1'b1};
         end
      end else if (flush_ff) begin
         rsp_ff <= '{range_first: pend_ff.range_first, range_total: pend_ff.range_total,
                     source_cell: pend_ff.source_cell, last_range: 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/clnr_cell_ram.sv
`timescale 1ns / 1ps

module clnr_cell_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [clnr_pkg::CELL_W-1:0]       wr_addr,
   input  clnr_pkg::clnr_entry_type          wr_data,
   input  logic                              rd_en,
   input  logic [clnr_pkg::CELL_W-1:0]       rd_addr,
   output clnr_pkg::clnr_entry_type          rd_data
);

   clnr_pkg::clnr_entry_type mem [clnr_pkg::NUM_CELLS];
   clnr_pkg::clnr_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/clnr_port_checker.sv
`timescale 1ns / 1ps
`include "cell_list_neighbor_ranges_defines.svh"

module clnr_port_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input clnr_pkg::clnr_req_type req_data,
   input logic                   rsp_valid,
   input clnr_pkg::clnr_rsp_type rsp_data
);

   // a query keeps the block busy into the next cycle
   `CLNR_ASSERT_NEXT(query_holds_busy, clock, reset,
      start && !busy && (req_data.req_type == clnr_pkg::REQ_QUERY), busy)

   // a fresh transaction never sees a result in the cycle after it
   `CLNR_ASSERT_NEXT(no_result_after_accept, clock, reset, start && !busy, !rsp_valid)

   // a range that is not the last comes while the query is still at work
   `CLNR_ASSERT_NOW(mid_range_while_busy, clock, reset,
      rsp_valid && !rsp_data.last_range, busy)

   // the last range closes the query: nothing follows at once
   `CLNR_ASSERT_NEXT(gap_after_last, clock, reset,
      rsp_valid && rsp_data.last_range, !rsp_valid)

endmodule

bind cell_list_neighbor_ranges clnr_port_checker u_port_checker (.*);
